// ----- src/mlfd_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package mlfd_pkg;

    localparam int HEADER_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC_VALUE = 1'b0,
        CFG_MAX_PAYLOAD = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_PAYLOAD   = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_MAGIC = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  payload_byte;
        logic [15:0] command;
        logic [15:0] frame_flags;
        logic [15:0] payload_length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

endpackage

// ----- src/mlfd_in_if.sv -----
// ----------------------------------------------------------------------------
// mlfd_in_if
// Byte stream channel into the deframer.
// ----------------------------------------------------------------------------
interface mlfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- src/mlfd_out_if.sv -----
// ----------------------------------------------------------------------------
// mlfd_out_if
// Result channel out of the deframer.
// ----------------------------------------------------------------------------
interface mlfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  payload_byte;
    logic [15:0] command;
    logic [15:0] frame_flags;
    logic [15:0] payload_length;
    logic        last;

    modport source (output valid, output status, output payload_byte, output command,
                    output frame_flags, output payload_length, output last, input ready);
    modport sink   (input valid, input status, input payload_byte, input command,
                    input frame_flags, input payload_length, input last, output ready);
endinterface

// ----- src/mlfd_front.sv -----
// ----------------------------------------------------------------------------
// mlfd_front
// Accepts stream bytes, captures the header, checks it and pushes a result into
// the queue for each payload byte, each empty frame and each header error.
// ----------------------------------------------------------------------------
module mlfd_front #(
    parameter int HEADER_BYTES = mlfd_pkg::HEADER_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mlfd_in_if.sink                        i_in,
    input  logic                           i_cfg_we,
    input  mlfd_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [mlfd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output mlfd_pkg::t_push                o_push,
    input  logic                           i_push_ready
);
    import mlfd_pkg::*;

    localparam int HP_W = $clog2(HEADER_BYTES + 1);
    localparam logic [HP_W-1:0] LAST_POS = HP_W'(HEADER_BYTES - 1);

    logic [HP_W-1:0] r_hdr_pos, n_hdr_pos;
    logic            r_in_payload, n_in_payload;
    logic            r_stopped, n_stopped;
    logic [15:0]     r_pay_cnt, n_pay_cnt;
    logic [15:0]     r_magic, n_magic;
    logic [15:0]     r_length, n_length;
    logic [15:0]     r_command, n_command;
    logic [15:0]     r_flags, n_flags;
    logic [15:0]     r_magic_value;
    logic [15:0]     r_max_payload;
    logic            accept;
    logic            is_last;
    t_push           push;

    assign i_in.ready = r_stopped || i_push_ready;
    assign accept     = i_in.valid && i_in.ready && !r_stopped;
    assign is_last    = ({1'b0, r_pay_cnt} + 17'd1) >= {1'b0, r_length};
    assign o_push     = push;

    always_comb begin
        n_hdr_pos    = r_hdr_pos;
        n_in_payload = r_in_payload;
        n_stopped    = r_stopped;
        n_pay_cnt    = r_pay_cnt;
        n_magic      = r_magic;
        n_length     = r_length;
        n_command    = r_command;
        n_flags      = r_flags;
        push         = '0;
        if (accept) begin
            if (!r_in_payload) begin
                if (r_hdr_pos < HP_W'(2)) begin
                    n_magic = {r_magic[7:0], i_in.data_byte};
                end else if (r_hdr_pos < HP_W'(4)) begin
                    n_length = {r_length[7:0], i_in.data_byte};
                end else if (r_hdr_pos < HP_W'(6)) begin
                    n_command = {r_command[7:0], i_in.data_byte};
                end else if (r_hdr_pos < HP_W'(8)) begin
                    n_flags = {r_flags[7:0], i_in.data_byte};
                end
                push.data.command        = n_command;
                push.data.frame_flags    = n_flags;
                push.data.payload_length = n_length;
                push.data.last           = 1'b1;
                push.data.payload_byte   = 8'd0;
                if (r_hdr_pos != LAST_POS) begin
                    n_hdr_pos = r_hdr_pos + HP_W'(1);
                end else begin
                    n_hdr_pos = '0;
                    if (n_magic != r_magic_value) begin
                        n_stopped        = 1'b1;
                        push.valid       = 1'b1;
                        push.data.status = ST_BAD_MAGIC;
                    end else if (n_length > r_max_payload) begin
                        n_stopped        = 1'b1;
                        push.valid       = 1'b1;
                        push.data.status = ST_TOO_LONG;
                    end else if (n_length == 16'd0) begin
                        push.valid       = 1'b1;
                        push.data.status = ST_EMPTY;
                    end else begin
                        n_in_payload = 1'b1;
                        n_pay_cnt    = 16'd0;
                    end
                end
            end else begin
                push.valid               = 1'b1;
                push.data.status         = ST_PAYLOAD;
                push.data.payload_byte   = i_in.data_byte;
                push.data.command        = r_command;
                push.data.frame_flags    = r_flags;
                push.data.payload_length = r_length;
                push.data.last           = is_last;
                if (is_last) begin
                    n_in_payload = 1'b0;
                end
                n_pay_cnt = r_pay_cnt + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos     <= '0;
            r_in_payload  <= 1'b0;
            r_stopped     <= 1'b0;
            r_pay_cnt     <= '0;
            r_magic       <= '0;
            r_length      <= '0;
            r_command     <= '0;
            r_flags       <= '0;
            r_magic_value <= '0;
            r_max_payload <= 16'hFFFF;
        end else begin
            r_hdr_pos    <= n_hdr_pos;
            r_in_payload <= n_in_payload;
            r_stopped    <= n_stopped;
            r_pay_cnt    <= n_pay_cnt;
            r_magic      <= n_magic;
            r_length     <= n_length;
            r_command    <= n_command;
            r_flags      <= n_flags;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAGIC_VALUE: r_magic_value <= i_cfg_wdata;
                    CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- src/mlfd_queue.sv -----
// ----------------------------------------------------------------------------
// mlfd_queue
// Short result queue between the front and back sides.
// ----------------------------------------------------------------------------
module mlfd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlfd_pkg::t_push   i_push,
    output logic              o_ready,
    output logic              o_valid,
    output mlfd_pkg::t_result o_data,
    input  logic              i_pop
);
    import mlfd_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    t_result         r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = r_count != QC_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push.valid && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QC_W'(1);
        end else if (!do_push && do_pop) begin
            n_count = r_count - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QP_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QP_W'(1);
            end
        end
    end

endmodule

// ----- src/mlfd_back.sv -----
// ----------------------------------------------------------------------------
// mlfd_back
// Output register: takes results from the queue and presents them on the
// result channel.
// ----------------------------------------------------------------------------
module mlfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mlfd_pkg::t_result i_data,
    output logic              o_pop,
    mlfd_out_if.source        o_out
);
    import mlfd_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_pop = i_valid && (!r_valid || o_out.ready);

    assign o_out.valid          = r_valid;
    assign o_out.status         = r_data.status;
    assign o_out.payload_byte   = r_data.payload_byte;
    assign o_out.command        = r_data.command;
    assign o_out.frame_flags    = r_data.frame_flags;
    assign o_out.payload_length = r_data.payload_length;
    assign o_out.last           = r_data.last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ----- src/magic_length_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// magic_length_frame_deframer
// Splits a byte stream into length-prefixed frames, checks magic and length,
// and emits payload bytes, empty-frame and error results tagged with the header words.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one stream byte per item; o_out carries one result per
//   payload byte, one per empty frame and one on a header error.
//   Header words are big-endian: magic, length, command, flags; header bytes
//   past the eighth are skipped.
//   The config port writes magic_value (index 0) and max_payload (index 1);
//   write only while the block is idle.
//   Throughput: one byte per cycle while the queue has room.
//   A result reaches o_out through the queue, written when its byte is
//   taken, and then the output register.
//   A stalled receiver fills the two-entry queue and the output register;
//   i_in.ready drops once the queue is full.
//   After a header error the block takes and drops every byte until reset.
//   Reset clears the parser, the queue, the output and the registers
//   (magic_value 0, max_payload 65535).
// ----------------------------------------------------------------------------
module magic_length_frame_deframer #(
    parameter int HEADER_BYTES = mlfd_pkg::HEADER_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mlfd_in_if.sink                         i_in,
    mlfd_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  mlfd_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [mlfd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import mlfd_pkg::*;

    t_push   push;
    logic    push_ready;
    logic    q_valid;
    t_result q_data;
    logic    pop;

    mlfd_front #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push),
        .i_push_ready(push_ready)
    );

    mlfd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_ready(push_ready),
        .o_valid(q_valid),
        .o_data (q_data),
        .i_pop  (pop)
    );

    mlfd_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_data (q_data),
        .o_pop  (pop),
        .o_out  (o_out)
    );

endmodule

// ----- src/mlfd_checker.sv -----
// ----------------------------------------------------------------------------
// mlfd_checker
// Port-level checks on the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module mlfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_status,
    input logic [7:0] i_out_payload_byte,
    input logic       i_out_last
);
    import mlfd_pkg::*;

    logic out_err;

    assign out_err = (i_out_status == ST_BAD_MAGIC) || (i_out_status == ST_TOO_LONG);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_payload_byte) && $stable(i_out_last))
        else $error("stalled result changed");

    a_nonpayload_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_PAYLOAD) |->
            i_out_last && (i_out_payload_byte == 8'd0))
        else $error("empty or error result not last or carries a byte");

    a_error_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && out_err |=> !i_out_valid)
        else $error("result after header error");

endmodule

bind magic_length_frame_deframer mlfd_checker u_mlfd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_status      (o_out.status),
    .i_out_payload_byte(o_out.payload_byte),
    .i_out_last        (o_out.last)
);
